// ----- rtl/bco_pkg.sv -----
`timescale 1ns / 1ps

package bco_pkg;

   localparam int MAX_LOG_SIZE = 9;
   localparam int NUM_LEVELS   = MAX_LOG_SIZE + 1;
   localparam int POS_W        = MAX_LOG_SIZE;
   localparam int SIZE_W       = 10;
   localparam int LEVEL_W      = 4;
   localparam int COUNT_W      = 19;
   localparam int PIXEL_W      = 8;
   localparam int CSR_IDX_W    = 1;

   localparam logic [PIXEL_W-1:0]   OBJECT_VALUE = 8'd255;
   localparam logic [SIZE_W-1:0]    MAX_SIDE     = SIZE_W'(1 << MAX_LOG_SIZE);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 1'b1;

   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [COUNT_W-1:0] count_type;

   function automatic size_type clamp_size(input size_type v);
      size_type s;
      s = v;
      if (s == '0) begin
         s = SIZE_W'(1);
      end
      if (s > MAX_SIDE) begin
         s = MAX_SIDE;
      end
      return s;
   endfunction

   function automatic level_type top_level(input size_type rows, input size_type cols);
      size_type  m;
      level_type k;
      m = (rows > cols) ? rows : cols;
      k = LEVEL_W'(MAX_LOG_SIZE);
      for (int i = MAX_LOG_SIZE - 1; i >= 0; i--) begin
         if ((SIZE_W'(1) << i) >= m) begin
            k = LEVEL_W'(i);
         end
      end
      return k;
   endfunction

endpackage

// ----- rtl/bco_ram.sv -----
`timescale 1ns / 1ps

module bco_ram #(
   parameter int ADDR_W = 1,
   parameter int DATA_W = 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/box_counting_occupancy.sv -----
`timescale 1ns / 1ps
// A pixel is registered in the input stage on its transfer and commits from there; the results
// of an image start the cycle after its last pixel commits, K+1 of them, one per cycle while
// rsp_stall is low. Throughput: one pixel per cycle; the last pixel of an image waits while
// the results of the previous image still drain from the result buffer.
// Reset and every register write run a clearing pass over the per-level occupancy memories,
// with req_stall held high.

module box_counting_occupancy (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bco_pkg::PIXEL_W-1:0]     req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bco_pkg::LEVEL_W-1:0]     rsp_level,
   output logic [bco_pkg::SIZE_W-1:0]      rsp_box_side,
   output logic [bco_pkg::COUNT_W-1:0]     rsp_box_count,
   output logic                            rsp_last_level,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bco_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bco_pkg::SIZE_W-1:0]      csr_data
);

   import bco_pkg::*;

   size_type  rows_ff, cols_ff;
   level_type k_top;

   pos_type   row_pos_ff, col_pos_ff;
   logic      clearing_ff;
   pos_type   clr_cnt_ff;

   logic      s1_valid_ff;
   logic      s1_obj_ff;
   pos_type   s1_row_ff, s1_col_ff;
   logic      s1_row_last_ff, s1_col_last_ff;
   logic [NUM_LEVELS-1:0] s1_fwd_ff, s1_fwd_val_ff;
   logic [NUM_LEVELS-1:0] fwd_in, fwd_val_in;
   logic [NUM_LEVELS-1:0] inc;

   count_type cnt_ff [NUM_LEVELS];
   count_type emit_cnt_ff [NUM_LEVELS];
   logic      emit_busy_ff;
   level_type emit_idx_ff, emit_k_ff;

   logic      csr_write;
   logic      req_accept, rsp_accept;
   logic      s1_end, commit;
   logic      col_last, row_last;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign k_top      = top_level(rows_ff, cols_ff);

   assign s1_end     = s1_row_last_ff & s1_col_last_ff;
   assign commit     = s1_valid_ff & ~(s1_end & emit_busy_ff);
   assign req_stall  = clearing_ff | (s1_valid_ff & ~commit);
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid & ~rsp_stall;

   assign col_last   = ({1'b0, col_pos_ff} == cols_ff - SIZE_W'(1));
   assign row_last   = ({1'b0, row_pos_ff} == rows_ff - SIZE_W'(1));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= MAX_SIDE;
         cols_ff <= MAX_SIDE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_ROWS: rows_ff <= clamp_size(csr_data);
            CSR_IMAGE_COLS: cols_ff <= clamp_size(csr_data);
            default: ;
         endcase
      end
   end

   // clearing pass and raster position
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         row_pos_ff  <= '0;
         col_pos_ff  <= '0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + POS_W'(1);
            if (clr_cnt_ff == '1) begin
               clearing_ff <= 1'b0;
            end
         end
         if (req_accept) begin
            if (col_last) begin
               col_pos_ff <= '0;
               row_pos_ff <= row_last ? '0 : row_pos_ff + POS_W'(1);
            end else begin
               col_pos_ff <= col_pos_ff + POS_W'(1);
            end
         end
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_obj_ff      <= (req_pixel_value == OBJECT_VALUE);
         s1_row_ff      <= row_pos_ff;
         s1_col_ff      <= col_pos_ff;
         s1_row_last_ff <= row_last;
         s1_col_last_ff <= col_last;
         s1_fwd_ff      <= fwd_in;
         s1_fwd_val_ff  <= fwd_val_in;
      end
   end

   // one occupancy lane per level
   for (genvar lv = 0; lv < NUM_LEVELS; lv++) begin : g_level
      localparam int AW = (lv == 0) ? 1 : lv;

      logic [LEVEL_W-1:0] shift;
      pos_type            mask, s1_off;
      logic [AW-1:0]      rd_addr, box_addr, wr_addr;
      logic               lv_on, first, box_end, row_end;
      logic               ram_q, occ_before, occ_new;
      logic               wr_en, wr_data;
      logic               cur_ff;

      assign shift    = k_top - LEVEL_W'(lv);
      assign lv_on    = (LEVEL_W'(lv) <= k_top);
      assign mask     = (POS_W'(1) << shift) - POS_W'(1);
      assign rd_addr  = AW'(col_pos_ff >> shift);
      assign box_addr = AW'(s1_col_ff >> shift);
      assign s1_off   = s1_col_ff & mask;
      assign first    = (s1_off == '0);
      assign box_end  = (s1_off == mask) | s1_col_last_ff;
      assign row_end  = (((s1_row_ff + POS_W'(1)) & mask) == '0) | s1_row_last_ff;

      assign occ_before = first ? (s1_fwd_ff[lv] ? s1_fwd_val_ff[lv] : ram_q) : cur_ff;
      assign occ_new    = occ_before | s1_obj_ff;
      assign inc[lv]    = lv_on & s1_obj_ff & ~occ_before;

      assign wr_en   = clearing_ff | (commit & lv_on & box_end);
      assign wr_addr = clearing_ff ? clr_cnt_ff[AW-1:0] : box_addr;
      assign wr_data = ~clearing_ff & occ_new & ~row_end;

      assign fwd_in[lv]     = commit & lv_on & box_end & (box_addr == rd_addr);
      assign fwd_val_in[lv] = occ_new & ~row_end;

      always_ff @(posedge clock) begin
         if (commit) begin
            cur_ff <= occ_new;
         end
      end

      bco_ram #(
         .ADDR_W(AW),
         .DATA_W(1)
      ) u_occ (
         .clock  (clock),
         .wr_en  (wr_en),
         .wr_addr(wr_addr),
         .wr_data(wr_data),
         .rd_en  (req_accept),
         .rd_addr(rd_addr),
         .rd_data(ram_q)
      );
   end

   // per-level counts and result buffer
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (commit) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_ff[i] <= s1_end ? '0 : cnt_ff[i] + COUNT_W'(inc[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit && s1_end) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            emit_cnt_ff[i] <= cnt_ff[i] + COUNT_W'(inc[i]);
         end
         emit_k_ff <= k_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else if (commit && s1_end) begin
         emit_busy_ff <= 1'b1;
         emit_idx_ff  <= '0;
      end else if (rsp_accept) begin
         if (emit_idx_ff == emit_k_ff) begin
            emit_busy_ff <= 1'b0;
         end else begin
            emit_idx_ff <= emit_idx_ff + LEVEL_W'(1);
         end
      end
   end

   assign rsp_valid      = emit_busy_ff;
   assign rsp_level      = emit_idx_ff;
   assign rsp_box_side   = SIZE_W'(1) << (emit_k_ff - emit_idx_ff);
   assign rsp_box_count  = emit_cnt_ff[emit_idx_ff];
   assign rsp_last_level = (emit_idx_ff == emit_k_ff);

endmodule
